// File: design/tcps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcps_pkg
// Shared types and constants for the constant-pad scatter address generator.
// ----------------------------------------------------------------------------
package tcps_pkg;

  localparam int DATA_BITS    = 32;
  localparam int INDEX_BITS   = 24;
  localparam int AXIS_BITS    = 12;
  localparam int CFG_IDX_BITS = 4;

  localparam logic [CFG_IDX_BITS-1:0] REG_FILL_VALUE   = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_PAD_BEFORE_0 = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] REG_PAD_BEFORE_1 = CFG_IDX_BITS'(2);
  localparam logic [CFG_IDX_BITS-1:0] REG_PAD_AFTER_1  = CFG_IDX_BITS'(3);
  localparam logic [CFG_IDX_BITS-1:0] REG_PAD_BEFORE_2 = CFG_IDX_BITS'(4);
  localparam logic [CFG_IDX_BITS-1:0] REG_PAD_AFTER_2  = CFG_IDX_BITS'(5);
  localparam logic [CFG_IDX_BITS-1:0] REG_SIZE_1       = CFG_IDX_BITS'(6);
  localparam logic [CFG_IDX_BITS-1:0] REG_SIZE_2       = CFG_IDX_BITS'(7);

  localparam logic OP_FILL = 1'b0;
  localparam logic OP_COPY = 1'b1;

  typedef struct packed {
    logic                 opcode;
    logic                 start_req;
    logic [DATA_BITS-1:0] in_value;
  } in_word_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0] dest_index;
    logic [DATA_BITS-1:0]  out_value;
    logic                  out_of_range;
  } out_word_t;

  typedef struct packed {
    logic [DATA_BITS-1:0]  fill_value;
    logic [INDEX_BITS:0]   base;
    logic [INDEX_BITS:0]   plane_jump;
    logic [AXIS_BITS:0]    row_side;
    logic [AXIS_BITS:0]    size_1;
    logic [AXIS_BITS:0]    size_2;
  } pad_geom_t;

endpackage

// File: design/tcps_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcps_cfg
// Configuration registers and a three-stage pipeline for base offset and jumps.
// ----------------------------------------------------------------------------
module tcps_cfg #(
  parameter int AXES = 3
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  input  logic [tcps_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [tcps_pkg::DATA_BITS-1:0]      cfg_data,
  output tcps_pkg::pad_geom_t                 geom,
  output logic                                busy
);
  import tcps_pkg::*;

  localparam int TW  = AXIS_BITS + 2;
  localparam int P1W = 2 * AXIS_BITS + 3;
  localparam int BW  = 3 * AXIS_BITS + 6;
  localparam logic [AXIS_BITS:0]  SMAX  = {1'b1, {AXIS_BITS{1'b0}}};
  localparam logic [AXIS_BITS:0]  SONE  = (AXIS_BITS+1)'(1);
  localparam logic [INDEX_BITS:0] IOVER = {1'b1, {INDEX_BITS{1'b0}}};

  function automatic logic [AXIS_BITS:0] clamp_size(input logic [AXIS_BITS:0] v);
    logic [AXIS_BITS:0] r;
    if (v == '0) r = SONE;
    else if (v > SMAX) r = SMAX;
    else r = v;
    return r;
  endfunction

  logic [DATA_BITS-1:0] fill_value_r;
  logic [AXIS_BITS-1:0] pb0_r, pb1_r, pa1_r, pb2_r, pa2_r;
  logic [AXIS_BITS:0]   size1_r, size2_r;
  logic [1:0]           busy_r, busy_nxt;

  logic [AXIS_BITS:0]   s1_e, s2_e;
  logic [AXIS_BITS-1:0] pb0_e, pb1_e, pa1_e;

  logic [TW-1:0]        row_len_r, t1_r;
  logic [AXIS_BITS:0]   side_r, mid_r;
  logic [P1W-1:0]       p1_r, plane_r;
  logic [BW-1:0]        base_full;
  logic [INDEX_BITS:0]  base_r, plane_sat_r;

  assign s1_e  = (AXES >= 2) ? clamp_size(size1_r) : SONE;
  assign s2_e  = clamp_size(size2_r);
  assign pb0_e = (AXES >= 3) ? pb0_r : '0;
  assign pb1_e = (AXES >= 2) ? pb1_r : '0;
  assign pa1_e = (AXES >= 2) ? pa1_r : '0;

  assign base_full = BW'(p1_r) * BW'(row_len_r) + BW'(pb2_r);

  assign busy_nxt = cfg_valid ? 2'd3 : ((busy_r != 2'd0) ? busy_r - 2'd1 : 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_value_r <= '0;
      pb0_r        <= '0;
      pb1_r        <= '0;
      pa1_r        <= '0;
      pb2_r        <= '0;
      pa2_r        <= '0;
      size1_r      <= SONE;
      size2_r      <= SONE;
      busy_r       <= 2'd3;
    end else begin
      busy_r <= busy_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_FILL_VALUE:   fill_value_r <= cfg_data;
          REG_PAD_BEFORE_0: pb0_r        <= cfg_data[AXIS_BITS-1:0];
          REG_PAD_BEFORE_1: pb1_r        <= cfg_data[AXIS_BITS-1:0];
          REG_PAD_AFTER_1:  pa1_r        <= cfg_data[AXIS_BITS-1:0];
          REG_PAD_BEFORE_2: pb2_r        <= cfg_data[AXIS_BITS-1:0];
          REG_PAD_AFTER_2:  pa2_r        <= cfg_data[AXIS_BITS-1:0];
          REG_SIZE_1:       size1_r      <= cfg_data[AXIS_BITS:0];
          REG_SIZE_2:       size2_r      <= cfg_data[AXIS_BITS:0];
          default: ;
        endcase
      end
    end
  end

  // derived geometry, free running behind the registers
  always_ff @(posedge clk) begin
    row_len_r   <= TW'(s2_e) + TW'(pb2_r) + TW'(pa2_r);
    t1_r        <= TW'(s1_e) + TW'(pb1_e) + TW'(pa1_e);
    side_r      <= (AXIS_BITS+1)'(pb2_r) + (AXIS_BITS+1)'(pa2_r);
    mid_r       <= (AXIS_BITS+1)'(pb1_e) + (AXIS_BITS+1)'(pa1_e);
    p1_r        <= P1W'(pb0_e) * P1W'(t1_r) + P1W'(pb1_e);
    plane_r     <= P1W'(mid_r) * P1W'(row_len_r);
    base_r      <= (base_full > BW'(IOVER)) ? IOVER : base_full[INDEX_BITS:0];
    plane_sat_r <= (plane_r > P1W'(IOVER)) ? IOVER : plane_r[INDEX_BITS:0];
  end

  assign geom.fill_value = fill_value_r;
  assign geom.base       = base_r;
  assign geom.plane_jump = plane_sat_r;
  assign geom.row_side   = side_r;
  assign geom.size_1     = s1_e;
  assign geom.size_2     = s2_e;
  assign busy            = (busy_r != 2'd0);

endmodule

// File: design/tcps_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcps_core
// Input register, index generation and result register with stall control.
// ----------------------------------------------------------------------------
module tcps_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 hold,
  input  tcps_pkg::pad_geom_t  geom,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tcps_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tcps_pkg::out_word_t  out_data
);
  import tcps_pkg::*;

  localparam int SW = INDEX_BITS + 2;
  localparam logic [INDEX_BITS-1:0] IMAX = {INDEX_BITS{1'b1}};

  logic                  stg_valid_r;
  in_word_t              stg_word_r;
  logic                  out_valid_r;
  out_word_t             out_data_r, out_nxt;

  logic [INDEX_BITS-1:0] fill_cnt_r, fill_cnt_nxt;
  logic                  fill_over_r, fill_over_nxt;
  logic [AXIS_BITS-1:0]  coord_mid_r, coord_mid_nxt;
  logic [AXIS_BITS-1:0]  coord_in_r, coord_in_nxt;
  logic [INDEX_BITS-1:0] copy_idx_r, copy_idx_nxt;
  logic                  copy_over_r, copy_over_nxt;

  logic [INDEX_BITS-1:0] cur_fill, cur_copy;
  logic                  cur_fill_over, cur_copy_over;
  logic [AXIS_BITS-1:0]  cur_mid, cur_in;
  logic [AXIS_BITS:0]    in_inc, mid_inc;
  logic                  wrap_in, wrap_mid, copy_flag;
  logic [SW-1:0]         sum, inc, next_copy;
  logic                  advance, proc;

  assign advance  = !out_valid_r || out_ready;
  assign proc     = stg_valid_r && advance;
  assign in_ready = !hold && (!stg_valid_r || advance);

  always_comb begin
    cur_fill      = stg_word_r.start_req ? '0   : fill_cnt_r;
    cur_fill_over = stg_word_r.start_req ? 1'b0 : fill_over_r;
    cur_copy      = stg_word_r.start_req ? '0   : copy_idx_r;
    cur_copy_over = stg_word_r.start_req ? 1'b0 : copy_over_r;
    cur_mid       = stg_word_r.start_req ? '0   : coord_mid_r;
    cur_in        = stg_word_r.start_req ? '0   : coord_in_r;

    in_inc    = (AXIS_BITS+1)'(cur_in) + (AXIS_BITS+1)'(1);
    mid_inc   = (AXIS_BITS+1)'(cur_mid) + (AXIS_BITS+1)'(1);
    wrap_in   = !(in_inc < geom.size_2);
    wrap_mid  = !(mid_inc < geom.size_1);
    sum       = SW'(geom.base) + SW'(cur_copy);
    copy_flag = cur_copy_over || (sum > SW'(IMAX));
    inc       = SW'(1)
              + (wrap_in ? SW'(geom.row_side) : '0)
              + ((wrap_in && wrap_mid) ? SW'(geom.plane_jump) : '0);
    next_copy = SW'(cur_copy) + inc;

    fill_cnt_nxt  = cur_fill;
    fill_over_nxt = cur_fill_over;
    coord_mid_nxt = cur_mid;
    coord_in_nxt  = cur_in;
    copy_idx_nxt  = cur_copy;
    copy_over_nxt = cur_copy_over;

    if (stg_word_r.opcode == OP_FILL) begin
      out_nxt.dest_index   = cur_fill_over ? IMAX : cur_fill;
      out_nxt.out_value    = geom.fill_value;
      out_nxt.out_of_range = cur_fill_over;
      if (cur_fill == IMAX) begin
        fill_over_nxt = 1'b1;
      end else begin
        fill_cnt_nxt = cur_fill + INDEX_BITS'(1);
      end
    end else begin
      out_nxt.dest_index   = copy_flag ? IMAX : sum[INDEX_BITS-1:0];
      out_nxt.out_value    = stg_word_r.in_value;
      out_nxt.out_of_range = copy_flag;
      if (!wrap_in) begin
        coord_in_nxt = in_inc[AXIS_BITS-1:0];
      end else begin
        coord_in_nxt = '0;
        coord_mid_nxt = wrap_mid ? '0 : mid_inc[AXIS_BITS-1:0];
      end
      if (next_copy > SW'(IMAX)) begin
        copy_idx_nxt  = IMAX;
        copy_over_nxt = 1'b1;
      end else begin
        copy_idx_nxt = next_copy[INDEX_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      fill_cnt_r  <= '0;
      fill_over_r <= 1'b0;
      coord_mid_r <= '0;
      coord_in_r  <= '0;
      copy_idx_r  <= '0;
      copy_over_r <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        stg_valid_r <= 1'b1;
      end else if (proc) begin
        stg_valid_r <= 1'b0;
      end
      if (proc) begin
        out_valid_r <= 1'b1;
        fill_cnt_r  <= fill_cnt_nxt;
        fill_over_r <= fill_over_nxt;
        coord_mid_r <= coord_mid_nxt;
        coord_in_r  <= coord_in_nxt;
        copy_idx_r  <= copy_idx_nxt;
        copy_over_r <= copy_over_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_word_r <= in_data;
    end
    if (proc) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: design/tensor_constant_pad_scatter_top.sv
`timescale 1ns / 1ps
// input then result register; one word per cycle while out_ready is high
// the input register takes a new word while a finished result waits on out_ready
// a config write holds in_ready low while the offset pipeline settles
// reset: synchronous active-low; counters cleared, sizes 1, pads and fill 0,
// inputs held off while the busy counter counts down after reset
// ----------------------------------------------------------------------------
// tensor_constant_pad_scatter_top
// Write-address generator for constant padding of a three-axis tensor.
// ----------------------------------------------------------------------------
module tensor_constant_pad_scatter_top #(
  parameter int AXES = 3
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  tcps_pkg::in_word_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output tcps_pkg::out_word_t                out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tcps_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [tcps_pkg::DATA_BITS-1:0]     cfg_data
);
  import tcps_pkg::*;

  pad_geom_t geom;
  logic      busy;

  assign cfg_ready = 1'b1;

  tcps_cfg #(
    .AXES (AXES)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .geom      (geom),
    .busy      (busy)
  );

  tcps_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .hold      (busy),
    .geom      (geom),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the constant-pad scatter address generator. A
// scoreboard class predicts every write (index, word, range flag) from its
// own copy of the geometry and counters. Directed words cover row and plane
// wraps, clamped sizes, base and running-offset saturation and ignored
// register bits. Random phases with fresh geometry follow, with bursty input
// gaps, output backpressure and one long output hold-off.
// ----------------------------------------------------------------------------
module testbench;
  import tcps_pkg::*;

  localparam longint unsigned IDX_MAX   = (64'd1 << INDEX_BITS) - 1;
  localparam longint unsigned AXIS_SPAN = 64'd1 << AXIS_BITS;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_LO = CFG_IDX_BITS'(8);
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_HI = '1;
  localparam int TOTAL_WORDS  = 650;
  localparam int CALM_WORDS   = 130;
  localparam int HOLD_CYCLES  = 60;
  localparam int CYCLE_LIMIT  = 200000;

  class scatter_board;
    bit [DATA_BITS-1:0]  fill_word;
    bit [AXIS_BITS-1:0]  pre0, pre1, post1, pre2, post2;
    bit [AXIS_BITS:0]    ext1, ext2;
    bit [INDEX_BITS-1:0] fill_pos, copy_off;
    bit [AXIS_BITS-1:0]  mid_pos, inner_pos;
    bit                  fill_sat, copy_sat;
    out_word_t           expected_writes[$];
    int                  errors;

    function new();
      fill_word = '0;
      pre0 = '0;
      pre1 = '0;
      post1 = '0;
      pre2 = '0;
      post2 = '0;
      ext1 = (AXIS_BITS+1)'(1);
      ext2 = (AXIS_BITS+1)'(1);
      errors = 0;
      restart();
    endfunction

    function void restart();
      fill_pos = '0;
      copy_off = '0;
      mid_pos = '0;
      inner_pos = '0;
      fill_sat = 1'b0;
      copy_sat = 1'b0;
    endfunction

    function longint unsigned extent(bit [AXIS_BITS:0] v);
      if (v == 0) return 1;
      if (v > AXIS_SPAN) return AXIS_SPAN;
      return 64'(v);
    endfunction

    function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [DATA_BITS-1:0] data);
      case (idx)
        REG_FILL_VALUE: begin
          fill_word = data;
        end
        REG_PAD_BEFORE_0: begin
          pre0 = data[AXIS_BITS-1:0];
        end
        REG_PAD_BEFORE_1: begin
          pre1 = data[AXIS_BITS-1:0];
        end
        REG_PAD_AFTER_1: begin
          post1 = data[AXIS_BITS-1:0];
        end
        REG_PAD_BEFORE_2: begin
          pre2 = data[AXIS_BITS-1:0];
        end
        REG_PAD_AFTER_2: begin
          post2 = data[AXIS_BITS-1:0];
        end
        REG_SIZE_1: begin
          ext1 = data[AXIS_BITS:0];
        end
        REG_SIZE_2: begin
          ext2 = data[AXIS_BITS:0];
        end
        default: begin
        end
      endcase
    endfunction

    function void predict_write(in_word_t w);
      longint unsigned s1, s2, row, plane, base, idx, step, nxt;
      bit flag;
      out_word_t r;
      if (w.start_req) restart();
      if (w.opcode == OP_FILL) begin
        flag = fill_sat;
        idx = fill_sat ? IDX_MAX : fill_pos;
        if (fill_pos >= IDX_MAX) begin
          fill_pos = INDEX_BITS'(IDX_MAX);
          fill_sat = 1'b1;
        end else begin
          fill_pos++;
        end
        r.out_value = fill_word;
      end else begin
        s1 = extent(ext1);
        s2 = extent(ext2);
        row = s2 + pre2 + post2;
        plane = s1 + pre1 + post1;
        base = (pre0 * plane + pre1) * row + pre2;
        idx = base + copy_off;
        flag = copy_sat || idx > IDX_MAX;
        if (flag) idx = IDX_MAX;
        step = 1;
        if (inner_pos + 1 < s2) begin
          inner_pos++;
        end else begin
          inner_pos = '0;
          step += pre2 + post2;
          if (mid_pos + 1 < s1) begin
            mid_pos++;
          end else begin
            mid_pos = '0;
            step += (pre1 + post1) * row;
          end
        end
        nxt = copy_off + step;
        if (nxt > IDX_MAX) begin
          copy_off = INDEX_BITS'(IDX_MAX);
          copy_sat = 1'b1;
        end else begin
          copy_off = INDEX_BITS'(nxt);
        end
        r.out_value = w.in_value;
      end
      r.dest_index = idx[INDEX_BITS-1:0];
      r.out_of_range = flag;
      expected_writes.push_back(r);
    endfunction

    function void check_write(out_word_t got);
      out_word_t exp;
      if (expected_writes.size() == 0) begin
        $display("%0t: unexpected write, expected none, actual index %0d word %h flag %b",
                 $time, got.dest_index, got.out_value, got.out_of_range);
        errors++;
        return;
      end
      exp = expected_writes.pop_front();
      if (got.dest_index !== exp.dest_index) begin
        $display("%0t: dest_index mismatch, expected %0d actual %0d",
                 $time, exp.dest_index, got.dest_index);
        errors++;
      end
      if (got.out_value !== exp.out_value) begin
        $display("%0t: out_value mismatch, expected %h actual %h",
                 $time, exp.out_value, got.out_value);
        errors++;
      end
      if (got.out_of_range !== exp.out_of_range) begin
        $display("%0t: out_of_range mismatch, expected %b actual %b",
                 $time, exp.out_of_range, got.out_of_range);
        errors++;
      end
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  in_word_t                in_data = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  out_word_t               out_data;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [DATA_BITS-1:0]    cfg_data = '0;

  scatter_board sb = new();
  bit gaps_on = 1'b0;
  int words_sent = 0;
  int holds_asked = 0;
  int holds_done = 0;
  int cycles = 0;

  tensor_constant_pad_scatter_top #(
    .AXES(3)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("testbench failed");
        $finish;
      end
    end
  end

  function automatic in_word_t make_word(logic op, logic start, logic [DATA_BITS-1:0] v);
    in_word_t w;
    w.opcode = op;
    w.start_req = start;
    w.in_value = v;
    return w;
  endfunction

  function automatic logic [DATA_BITS-1:0] pad_word();
    logic [DATA_BITS-1:0] v;
    case ($urandom_range(0, 9))
      0: begin
        v = DATA_BITS'(AXIS_SPAN - 1);
      end
      1: begin
        v = $urandom_range(0, AXIS_SPAN - 1);
      end
      default: begin
        v = $urandom_range(0, 3);
      end
    endcase
    if ($urandom_range(0, 1)) v[DATA_BITS-1:AXIS_BITS] = (DATA_BITS-AXIS_BITS)'($urandom);
    return v;
  endfunction

  function automatic logic [DATA_BITS-1:0] size_word();
    logic [DATA_BITS-1:0] v;
    case ($urandom_range(0, 11))
      0: begin
        v = 0;
      end
      1: begin
        v = DATA_BITS'(AXIS_SPAN);
      end
      2: begin
        v = $urandom_range(0, 2 * AXIS_SPAN - 1);
      end
      default: begin
        v = $urandom_range(1, 6);
      end
    endcase
    if ($urandom_range(0, 1)) begin
      v[DATA_BITS-1:AXIS_BITS+1] = (DATA_BITS-AXIS_BITS-1)'($urandom);
    end
    return v;
  endfunction

  task automatic send_word(in_word_t w);
    int gap;
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    sb.predict_write(w);
    words_sent++;
    gap = (gaps_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 7) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // drop valid and wait until every write has come back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_writes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(logic [CFG_IDX_BITS-1:0] idx, logic [DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  task automatic random_config();
    put_reg(REG_FILL_VALUE, $urandom);
    put_reg(REG_PAD_BEFORE_0, pad_word());
    put_reg(REG_PAD_BEFORE_1, pad_word());
    put_reg(REG_PAD_AFTER_1, pad_word());
    put_reg(REG_PAD_BEFORE_2, pad_word());
    put_reg(REG_PAD_AFTER_2, pad_word());
    put_reg(REG_SIZE_1, size_word());
    put_reg(REG_SIZE_2, size_word());
    if ($urandom_range(0, 5) == 0) begin
      put_reg(CFG_IDX_BITS'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), $urandom);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic random_stream(int count, bit noisy, bit pause_mid);
    in_word_t w;
    for (int k = 0; k < count; k++) begin
      if (pause_mid && k == count / 2) settle();
      if (noisy) begin
        w = make_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom);
      end else begin
        w = make_word(($urandom_range(0, 9) < 7) ? OP_COPY : OP_FILL,
                      (k == 0) || ($urandom_range(0, 39) == 0), $urandom);
      end
      send_word(w);
    end
  endtask

  initial begin : result_side
    int stall;
    int hold;
    stall = 0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) sb.check_write(out_data);
      if (holds_done != holds_asked) begin
        holds_done++;
        hold = HOLD_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(0, 6);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int phase;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset geometry: every copy lands on the next index
    send_word(make_word(OP_FILL, 1'b1, $urandom));
    send_word(make_word(OP_COPY, 1'b0, '0));
    send_word(make_word(OP_COPY, 1'b0, '1));
    settle();

    // small geometry with row and plane wraps
    put_reg(REG_FILL_VALUE, '1);
    put_reg(REG_PAD_BEFORE_0, 1);
    put_reg(REG_PAD_BEFORE_1, 1);
    put_reg(REG_PAD_AFTER_1, 2);
    put_reg(REG_PAD_BEFORE_2, 2);
    put_reg(REG_PAD_AFTER_2, 1);
    put_reg(REG_SIZE_1, 2);
    put_reg(REG_SIZE_2, 3);
    cfg_valid <= 1'b0;
    send_word(make_word(OP_COPY, 1'b1, $urandom));
    repeat (5) send_word(make_word(OP_COPY, 1'b0, $urandom));
    send_word(make_word(OP_FILL, 1'b0, $urandom));
    send_word(make_word(OP_FILL, 1'b0, $urandom));
    settle();

    // largest pads with stray upper bits, zero and oversize extents
    put_reg(REG_FILL_VALUE, '0);
    put_reg(REG_PAD_BEFORE_0, '1);
    put_reg(REG_PAD_BEFORE_1, '1);
    put_reg(REG_PAD_AFTER_1, '1);
    put_reg(REG_PAD_BEFORE_2, '1);
    put_reg(REG_PAD_AFTER_2, '1);
    put_reg(REG_SIZE_1, '0);
    put_reg(REG_SIZE_2, '1);
    cfg_valid <= 1'b0;
    send_word(make_word(OP_COPY, 1'b1, $urandom));
    send_word(make_word(OP_COPY, 1'b0, $urandom));
    send_word(make_word(OP_FILL, 1'b1, $urandom));
    send_word(make_word(OP_FILL, 1'b0, $urandom));
    settle();

    // running offset saturates after one step, start clears it
    put_reg(REG_PAD_BEFORE_0, '0);
    put_reg(REG_PAD_BEFORE_1, '0);
    put_reg(REG_PAD_BEFORE_2, '0);
    put_reg(REG_SIZE_1, 1);
    put_reg(REG_SIZE_2, 1);
    put_reg(REG_SPARE_LO, '1);
    put_reg(REG_SPARE_HI, '1);
    cfg_valid <= 1'b0;
    send_word(make_word(OP_COPY, 1'b1, $urandom));
    send_word(make_word(OP_COPY, 1'b0, $urandom));
    send_word(make_word(OP_COPY, 1'b0, $urandom));
    send_word(make_word(OP_COPY, 1'b1, $urandom));

    phase = 0;
    gaps_on = 1'b1;
    while (words_sent < TOTAL_WORDS) begin
      settle();
      random_config();
      if (phase == 2) holds_asked++;
      if (words_sent >= TOTAL_WORDS - CALM_WORDS) gaps_on = 1'b0;
      random_stream($urandom_range(20, 60), $urandom_range(0, 4) == 0, phase == 4);
      phase++;
    end

    settle();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.expected_writes.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/tcps_pkg.sv
design/tcps_cfg.sv
design/tcps_core.sv
design/tensor_constant_pad_scatter_top.sv
sim/testbench.sv
